/* sv/dynamic_convex_hull_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the convex hull unit checker.
// Each macro is one concurrent assertion clocked by clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_CONVEX_HULL_UNIT_ASSERT_SVH
`define DYNAMIC_CONVEX_HULL_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DCH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DCH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dch_pkg.sv */
// ----------------------------------------------------------------------------
// dch_pkg
// Shared constants for the convex hull unit and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dch_pkg;

  // Defaults for the top level parameters
  localparam int HULL_DEPTH_DEF = 256;
  localparam int COORD_BITS_DEF = 31;

  // Fixed field widths on the ports
  localparam int FIELD_W    = 31;
  localparam int S_TDATA_W  = 64;
  localparam int M_TDATA_W  = 8;

  // Operation codes carried in s_tuser
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Bit positions in m_tdata
  localparam int OUT_INSIDE_BIT = 0;
  localparam int OUT_OVF_BIT    = 1;

endpackage

/* sv/dynamic_convex_hull_unit.sv */
// ----------------------------------------------------------------------------
// dynamic_convex_hull_unit
// Keeps upper and lower hull chains and answers point-in-hull queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid/s_tready with the point in s_tdata and the
//   operation (insert or query) in s_tuser. Each item gives exactly one result
//   item on m_tvalid/m_tready: inside flag for a query, overflow flag for an
//   insert.
//   Both chains live in one RAM (upper in the low half, lower in the high
//   half); a small sequencer walks them one entry per access and shares one
//   signed multiplier for all cross products. Per item it runs a linear
//   search on each chain, moves entries up or down on insert or removal,
//   and checks convexity around the changed entry; each chain holds at
//   most HULL_DEPTH entries.
//   s_tready is high only while the sequencer is idle. A finished result sits
//   in the output register, so the next item may be taken while it waits;
//   if m_tready stays low the sequencer holds before writing the next result.
//   Reset clears both chain counts and the output register; RAM contents are
//   never read beyond the counts, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dynamic_convex_hull_unit
  import dch_pkg::*;
#(
  parameter int HULL_DEPTH = HULL_DEPTH_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // point_x[30:0], point_y[61:31], zero pad
  input  logic                 s_tuser,   // operation
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata    // inside_res[0], overflow[1], zero pad
);

  localparam int AW = $clog2(HULL_DEPTH);
  localparam int CW = $clog2(HULL_DEPTH + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int RW = PW + 1;
  localparam int EW = 2 * COORD_BITS;
  localparam int RAM_DEPTH = 2 << AW;

  // Sequencer states
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_SEEK_RD  = 5'd1;
  localparam logic [4:0] S_SEEK_CHK = 5'd2;
  localparam logic [4:0] S_EVAL     = 5'd3;
  localparam logic [4:0] S_MUL1     = 5'd4;
  localparam logic [4:0] S_MUL2     = 5'd5;
  localparam logic [4:0] S_MUL3     = 5'd6;
  localparam logic [4:0] S_COVX     = 5'd7;
  localparam logic [4:0] S_DECIDE   = 5'd8;
  localparam logic [4:0] S_SHIFT_UP = 5'd9;
  localparam logic [4:0] S_SHU_WR   = 5'd10;
  localparam logic [4:0] S_PL_INIT  = 5'd11;
  localparam logic [4:0] S_CHK      = 5'd12;
  localparam logic [4:0] S_RD_A     = 5'd13;
  localparam logic [4:0] S_RD_B     = 5'd14;
  localparam logic [4:0] S_RD_C     = 5'd15;
  localparam logic [4:0] S_RD_D     = 5'd16;
  localparam logic [4:0] S_CONC     = 5'd17;
  localparam logic [4:0] S_DROP     = 5'd18;
  localparam logic [4:0] S_DROP_WR  = 5'd19;
  localparam logic [4:0] S_PR_INIT  = 5'd20;
  localparam logic [4:0] S_NEXT     = 5'd21;
  localparam logic [4:0] S_OUT      = 5'd22;

  logic [4:0] state;
  logic [4:0] ret;

  logic                         op;
  logic                         chain;      // 0 upper, 1 lower
  logic                         side_right; // pruning right side
  logic signed [COORD_BITS-1:0] px, py;
  logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;
  logic signed [COORD_BITS-1:0] prev_x, prev_y, cur_x, cur_y;
  logic [CW-1:0]                n_up, n_lo;
  logic [CW-1:0]                i, p, j;
  logic                         cov, in_hull, ovf;
  logic signed [PW-1:0]         prod, acc;
  logic signed [RW-1:0]         cr;

  // RAM ports
  logic            we;
  logic [AW:0]     waddr, raddr;
  logic [EW-1:0]   wdata, rdata;
  logic [CW-1:0]   ridx, widx;

  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  logic [CW-1:0]                n_cur;
  logic [CW:0]                  p_plus1;
  logic signed [DW-1:0]         ux, uy, vx, vy, mul_a, mul_b;
  logic signed [PW-1:0]         mul_p;
  logic                         side_ok;

  assign rd_x  = rdata[COORD_BITS-1:0];
  assign rd_y  = rdata[EW-1:COORD_BITS];
  assign n_cur = chain ? n_lo : n_up;
  assign p_plus1 = {1'b0, p} + {{CW{1'b0}}, 1'b1};

  // Shared cross product datapath
  assign ux = {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
  assign uy = {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
  assign vx = {cx[COORD_BITS-1], cx} - {ax[COORD_BITS-1], ax};
  assign vy = {cy[COORD_BITS-1], cy} - {ay[COORD_BITS-1], ay};
  assign mul_a = (state == S_MUL1) ? ux : uy;
  assign mul_b = (state == S_MUL1) ? vy : vx;
  assign mul_p = mul_a * mul_b;

  // Upper chain wants cross >= 0, lower chain cross <= 0
  assign side_ok = chain ? (cr[RW-1] || (cr == '0)) : !cr[RW-1];

  assign s_tready = (state == S_IDLE);

  // RAM address and write control
  always_comb begin
    we    = 1'b0;
    ridx  = '0;
    widx  = i;
    wdata = {py, px};
    unique case (state)
      S_SEEK_RD:  ridx = i;
      S_SHIFT_UP: begin
        ridx = j - CW'(1);
        we   = (j == i);
      end
      S_SHU_WR: begin
        we    = 1'b1;
        widx  = j;
        wdata = rdata;
      end
      S_DECIDE:   we = (op == OP_INSERT) && !cov && (i < n_cur) && (cur_x == px);
      S_RD_A:     ridx = p - CW'(1);
      S_RD_B:     ridx = p;
      S_RD_C:     ridx = p_plus1[CW-1:0];
      S_DROP:     ridx = j + CW'(1);
      S_DROP_WR: begin
        we    = 1'b1;
        widx  = j;
        wdata = rdata;
      end
      default: ;
    endcase
    raddr = {chain, ridx[AW-1:0]};
    waddr = {chain, widx[AW-1:0]};
  end

  dch_ram #(
    .WIDTH(EW),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      n_up     <= '0;
      n_lo     <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op      <= s_tuser;
            px      <= s_tdata[COORD_BITS-1:0];
            py      <= s_tdata[FIELD_W + COORD_BITS - 1:FIELD_W];
            chain   <= 1'b0;
            i       <= '0;
            in_hull <= 1'b1;
            ovf     <= 1'b0;
            state   <= S_SEEK_RD;
          end
        end
        // Linear search for first x >= px
        S_SEEK_RD: begin
          state <= (i == n_cur) ? S_EVAL : S_SEEK_CHK;
        end
        S_SEEK_CHK: begin
          if (rd_x < px) begin
            prev_x <= rd_x;
            prev_y <= rd_y;
            i      <= i + CW'(1);
          end else begin
            cur_x <= rd_x;
            cur_y <= rd_y;
          end
          state <= (rd_x < px) ? S_SEEK_RD : S_EVAL;
        end
        // Coverage test
        S_EVAL: begin
          if (i >= n_cur) begin
            cov   <= 1'b0;
            state <= S_DECIDE;
          end else if (cur_x == px) begin
            cov   <= chain ? (py >= cur_y) : (py <= cur_y);
            state <= S_DECIDE;
          end else if (i == '0) begin
            cov   <= 1'b0;
            state <= S_DECIDE;
          end else begin
            ax    <= prev_x;
            ay    <= prev_y;
            bx    <= px;
            by    <= py;
            cx    <= cur_x;
            cy    <= cur_y;
            ret   <= S_COVX;
            state <= S_MUL1;
          end
        end
        // Two products through one multiplier, then the difference
        S_MUL1: begin
          prod  <= mul_p;
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= prod;
          prod  <= mul_p;
          state <= S_MUL3;
        end
        S_MUL3: begin
          cr    <= {acc[PW-1], acc} - {prod[PW-1], prod};
          state <= ret;
        end
        S_COVX: begin
          cov   <= side_ok;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (op == OP_QUERY) begin
            in_hull <= in_hull & cov;
            state   <= S_NEXT;
          end else if (cov) begin
            state <= S_NEXT;
          end else if ((i < n_cur) && (cur_x == px)) begin
            state <= S_PL_INIT;
          end else if (n_cur == CW'(HULL_DEPTH)) begin
            ovf   <= 1'b1;
            state <= S_NEXT;
          end else begin
            j     <= n_cur;
            state <= S_SHIFT_UP;
          end
        end
        // Open a slot at i by moving entries up
        S_SHIFT_UP: begin
          if (j == i) begin
            if (chain) n_lo <= n_lo + CW'(1);
            else       n_up <= n_up + CW'(1);
            state <= S_PL_INIT;
          end else begin
            state <= S_SHU_WR;
          end
        end
        S_SHU_WR: begin
          j     <= j - CW'(1);
          state <= S_SHIFT_UP;
        end
        S_PL_INIT: begin
          side_right <= 1'b0;
          p          <= i - CW'(1);
          state      <= (i == '0) ? S_PR_INIT : S_CHK;
        end
        S_PR_INIT: begin
          side_right <= 1'b1;
          p          <= i + CW'(1);
          state      <= S_CHK;
        end
        // Convexity check at p
        S_CHK: begin
          if ((p == '0) || (p_plus1 >= {1'b0, n_cur})) begin
            state <= side_right ? S_NEXT : S_PR_INIT;
          end else begin
            state <= S_RD_A;
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          ax    <= rd_x;
          ay    <= rd_y;
          state <= S_RD_C;
        end
        S_RD_C: begin
          bx    <= rd_x;
          by    <= rd_y;
          state <= S_RD_D;
        end
        S_RD_D: begin
          cx    <= rd_x;
          cy    <= rd_y;
          ret   <= S_CONC;
          state <= S_MUL1;
        end
        S_CONC: begin
          if (side_ok) begin
            j     <= p;
            state <= S_DROP;
          end else begin
            state <= side_right ? S_NEXT : S_PR_INIT;
          end
        end
        // Remove entry p by moving entries down
        S_DROP: begin
          if ({1'b0, j} + {{CW{1'b0}}, 1'b1} >= {1'b0, n_cur}) begin
            if (chain) n_lo <= n_lo - CW'(1);
            else       n_up <= n_up - CW'(1);
            if (!side_right) begin
              p <= p - CW'(1);
              i <= i - CW'(1);
            end
            state <= S_CHK;
          end else begin
            state <= S_DROP_WR;
          end
        end
        S_DROP_WR: begin
          j     <= j + CW'(1);
          state <= S_DROP;
        end
        S_NEXT: begin
          if (!chain) begin
            chain <= 1'b1;
            i     <= '0;
            state <= S_SEEK_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid                <= 1'b1;
            m_tdata                 <= '0;
            m_tdata[OUT_INSIDE_BIT] <= (op == OP_QUERY) && in_hull;
            m_tdata[OUT_OVF_BIT]    <= (op == OP_INSERT) && ovf;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/dch_ram.sv */
// ----------------------------------------------------------------------------
// dch_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/dch_checker.sv */
// ----------------------------------------------------------------------------
// dch_checker
// Port-level checks for the convex hull unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dynamic_convex_hull_unit_assert.svh"

module dch_checker
  import dch_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic                 s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // Stalled result stays offered
  `DCH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

  // Stalled result payload holds
  `DCH_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

  // A result is never both an inside answer and an overflow flag
  `DCH_ASSERT_NOW(a_one_flag, m_tvalid, !(m_tdata[OUT_INSIDE_BIT] && m_tdata[OUT_OVF_BIT]), "both flags set")

  // An accepted item keeps the unit busy on the next cycle
  `DCH_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "ready right after accept")

endmodule

bind dynamic_convex_hull_unit dch_checker u_dch_checker (.*);
